FILE: src/half_step_motor_sequencer_core_assert.svh
// Assertion macros used by the checker file.
`ifndef HALF_STEP_MOTOR_SEQUENCER_CORE_ASSERT_SVH
`define HALF_STEP_MOTOR_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HSMS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hsms assertion failed");

// Next-cycle implication.
`define HSMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hsms assertion failed");

`endif

FILE: src/hsms_pkg.sv
package hsms_pkg;

    localparam int SPEED_NUM     = 60000000 / 4096;
    localparam int DIV_BITS      = 14;
    localparam int DIV_CNT_W     = $clog2(DIV_BITS);
    localparam int SPEED_W       = 12;
    localparam int DELAY_W       = 16;
    localparam int COUNT_W       = 16;
    localparam int POS_W         = 32;
    localparam int COIL_W        = 4;
    localparam int PHASE_W       = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [DIV_BITS-1:0] DIV_DIVIDEND  = DIV_BITS'(SPEED_NUM);
    localparam logic [DELAY_W-1:0]  DEFAULT_DELAY = 16'd2000;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam logic CFG_ENABLE        = 1'b0;
    localparam logic CFG_DEFAULT_DELAY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_DISABLED = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } stat_t;

    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] c;
        case (phase)
            3'd0:    c = 4'h1;
            3'd1:    c = 4'h3;
            3'd2:    c = 4'h2;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h4;
            3'd5:    c = 4'hC;
            3'd6:    c = 4'h8;
            3'd7:    c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage

FILE: src/hsms_ctrl.sv
module hsms_ctrl
    import hsms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        IDLE,
        DIVIDE,
        EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load     = (state_reg == IDLE) && in_valid;
        cmd.div_step = (state_reg == DIVIDE);
        cmd.exec     = (state_reg == EXEC) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = stat.need_div ? DIVIDE : EXEC;
                end
            end
            DIVIDE:
            begin
                if (stat.div_last)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next     = IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: src/hsms_dp.sv
module hsms_dp
    import hsms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      op,
    input  logic signed [COUNT_W-1:0] step_count,
    input  logic [SPEED_W-1:0]        speed,
    output logic [COIL_W-1:0]         coils,
    output logic signed [POS_W-1:0]   position,
    output logic                      busy_res,
    output logic                      stepped,
    output logic [1:0]                status
);

    logic                 enable_reg;
    logic [DELAY_W-1:0]   dflt_delay_reg;

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [COIL_W-1:0]    coil_reg, coil_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic [DELAY_W-1:0]   timer_reg, timer_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic                 down_reg, down_next;
    logic                 moving_reg, moving_next;

    logic                 op_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [SPEED_W-1:0]   spd_reg;

    logic [SPEED_W-1:0]   rem_reg;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SPEED_W:0]     partial;
    logic [SPEED_W:0]     diff;

    logic [COIL_W-1:0]    o_coils_next;
    logic [POS_W-1:0]     o_pos_next;
    logic                 o_stepped_next;
    status_t              o_status_next;

    logic [COIL_W-1:0]    o_coils_reg;
    logic [POS_W-1:0]     o_pos_reg;
    logic                 o_busy_reg;
    logic                 o_stepped_reg;
    status_t              o_status_reg;

    assign stat.need_div = (op == OP_MOVE) && enable_reg && !moving_reg
                           && (step_count != '0) && (speed != '0);
    assign stat.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_BITS - 1));

    assign partial = {rem_reg, quo_reg[DIV_BITS-1]};
    assign diff    = partial - {1'b0, spd_reg};

    always_comb
    begin
        logic               take;
        logic               neg;
        logic [COUNT_W-1:0] mag;
        logic [DELAY_W-1:0] d;

        take        = 1'b0;
        neg         = cnt_reg[COUNT_W-1];
        mag         = neg ? COUNT_W'(-cnt_reg) : cnt_reg;
        d           = (spd_reg != '0) ? DELAY_W'(quo_reg) : dflt_delay_reg;
        phase_next  = phase_reg;
        coil_next   = coil_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        timer_next  = timer_reg;
        delay_next  = delay_reg;
        down_next   = down_reg;
        moving_next = moving_reg;
        o_stepped_next = 1'b0;
        o_status_next  = ST_OK;

        if (d == '0)
        begin
            d = DELAY_W'(1);
        end

        if (op_reg == OP_MOVE)
        begin
            if (!enable_reg)
            begin
                o_status_next = ST_DISABLED;
            end
            else if (moving_reg)
            begin
                o_status_next = ST_BUSY;
            end
            else if (cnt_reg != '0)
            begin
                delay_next  = d;
                down_next   = neg;
                left_next   = mag;
                moving_next = 1'b1;
                take        = 1'b1;
            end
        end
        else
        begin
            if (!enable_reg)
            begin
                o_status_next = ST_DISABLED;
            end
            if (moving_reg)
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - 1'b1;
                end
                if (timer_next == '0)
                begin
                    if (left_reg != '0)
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        moving_next = 1'b0;
                    end
                end
            end
        end

        if (take)
        begin
            phase_next = down_next ? phase_reg - 1'b1 : phase_reg + 1'b1;
            coil_next  = coil_of(phase_next);
            pos_next   = down_next ? pos_reg - 1'b1 : pos_reg + 1'b1;
            left_next  = left_next - 1'b1;
            timer_next = delay_next;
            o_stepped_next = 1'b1;
        end

        o_coils_next = coil_next;
        o_pos_next   = enable_reg ? pos_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            dflt_delay_reg <= DEFAULT_DELAY;
            phase_reg      <= '0;
            coil_reg       <= '0;
            pos_reg        <= '0;
            left_reg       <= '0;
            timer_reg      <= '0;
            delay_reg      <= '0;
            down_reg       <= 1'b0;
            moving_reg     <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:        enable_reg     <= cfg_data[0];
                    CFG_DEFAULT_DELAY: dflt_delay_reg <= cfg_data;
                    default:           enable_reg     <= enable_reg;
                endcase
            end
            if (cmd.load)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                phase_reg  <= phase_next;
                coil_reg   <= coil_next;
                pos_reg    <= pos_next;
                left_reg   <= left_next;
                timer_reg  <= timer_next;
                delay_reg  <= delay_next;
                down_reg   <= down_next;
                moving_reg <= moving_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            cnt_reg <= $unsigned(step_count);
            spd_reg <= speed;
            rem_reg <= '0;
            quo_reg <= DIV_DIVIDEND;
        end
        else if (cmd.div_step)
        begin
            if (!diff[SPEED_W])
            begin
                rem_reg <= diff[SPEED_W-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= partial[SPEED_W-1:0];
                quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
            end
        end
        if (cmd.exec)
        begin
            o_coils_reg   <= o_coils_next;
            o_pos_reg     <= o_pos_next;
            o_busy_reg    <= moving_next;
            o_stepped_reg <= o_stepped_next;
            o_status_reg  <= o_status_next;
        end
    end

    assign coils    = o_coils_reg;
    assign position = $signed(o_pos_reg);
    assign busy_res = o_busy_reg;
    assign stepped  = o_stepped_reg;
    assign status   = o_status_reg;

endmodule

FILE: src/half_step_motor_sequencer_core.sv
// A tick, or a move without speed, goes from IDLE to EXEC; EXEC writes the result.
// A move with nonzero speed and steps, when enabled and not moving, passes DIVIDE
// first for the bit-serial delay divider. A new request is taken only in IDLE.
// The output register frees the input side while a result waits.
// Reset (rst_n low, async): idle, coil/position state 0, disabled, default delay 2000.
module half_step_motor_sequencer_core
    import hsms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic signed [COUNT_W-1:0] step_count,
    input  logic [SPEED_W-1:0]        speed,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COIL_W-1:0]         coils,
    output logic signed [POS_W-1:0]   position,
    output logic                      busy_res,
    output logic                      stepped,
    output logic [1:0]                status
);

    cmd_t  cmd;
    stat_t stat;

    hsms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hsms_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .step_count (step_count),
        .speed      (speed),
        .coils      (coils),
        .position   (position),
        .busy_res   (busy_res),
        .stepped    (stepped),
        .status     (status)
    );

endmodule

FILE: src/hsms_checker.sv
`include "half_step_motor_sequencer_core_assert.svh"

module hsms_checker
    import hsms_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [COIL_W-1:0]         coils,
    input logic signed [POS_W-1:0]   position,
    input logic                      busy_res,
    input logic                      stepped,
    input logic [1:0]                status
);

    `HSMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(coils) && $stable(position) && $stable(status))
    `HSMS_ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && !in_stall, in_stall)
    `HSMS_ASSERT_NOW(a_disabled_pos, clk, rst_n, out_valid && (status == ST_DISABLED), position == '0)
    `HSMS_ASSERT_NOW(a_step_busy, clk, rst_n, out_valid && stepped, busy_res && (coils != '0))
    `HSMS_ASSERT_NOW(a_reject_busy, clk, rst_n, out_valid && (status == ST_BUSY), busy_res && !stepped)

endmodule

bind half_step_motor_sequencer_core hsms_checker u_hsms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .coils     (coils),
    .position  (position),
    .busy_res  (busy_res),
    .stepped   (stepped),
    .status    (status)
);
